>>> rtl/rgbs_pkg.sv
// shared constants, types and helpers for the rgb565 grey / binarize / stats block
`timescale 1ns / 1ps

package rgbs_pkg;

  localparam int unsigned MaxFramePixels = 32768;
  localparam int unsigned TallyCeil      = 65535;
  localparam int unsigned TallyCap       = (MaxFramePixels < TallyCeil) ? MaxFramePixels
                                                                        : TallyCeil;

  localparam int PixelW = 16;
  localparam int TallyW = 16;
  localparam int SumW   = 23;
  localparam int LumaW  = 8;
  localparam int ModeW  = 2;
  localparam int ThrW   = 8;
  localparam int OutW   = 112;

  localparam logic [TallyW-1:0] TallyCapV = TallyW'(TallyCap);
  localparam logic [SumW-1:0]   SumCeil   = {SumW{1'b1}};
  localparam logic [LumaW-1:0]  DarkLimit   = 8'd30;
  localparam logic [LumaW-1:0]  BrightLimit = 8'd240;

  localparam logic [ModeW-1:0] ModeBypass = 2'd0;
  localparam logic [ModeW-1:0] ModeGray   = 2'd1;
  localparam logic [ModeW-1:0] ModeBinary = 2'd2;

  localparam logic RegMode      = 1'b0;
  localparam logic RegThreshold = 1'b1;

  typedef struct packed {
    logic [TallyW-1:0] count;
    logic [SumW-1:0]   total;
    logic [LumaW-1:0]  low;
    logic [LumaW-1:0]  high;
    logic [TallyW-1:0] dark;
    logic [TallyW-1:0] bright;
    logic [ThrW-1:0]   snap;
  } stats_t;

  function automatic stats_t stats_clear(input logic [ThrW-1:0] snap);
    stats_t s;
    s.count  = '0;
    s.total  = '0;
    s.low    = '1;
    s.high   = '0;
    s.dark   = '0;
    s.bright = '0;
    s.snap   = snap;
    return s;
  endfunction

endpackage

>>> rtl/rgbs_luma.sv
// rgb565 luma computation and output pixel selection by mode
`timescale 1ns / 1ps

module rgbs_luma (
  input  logic [rgbs_pkg::PixelW-1:0] pixel_i,
  input  logic [rgbs_pkg::ModeW-1:0]  mode_i,
  input  logic [rgbs_pkg::ThrW-1:0]   threshold_i,
  output logic [rgbs_pkg::LumaW-1:0]  luma_o,
  output logic [rgbs_pkg::PixelW-1:0] pixel_o
);

  logic [4:0]  r5, b5;
  logic [5:0]  g6;
  logic [7:0]  r8, g8, b8;
  logic [15:0] wsum;

  assign r5 = pixel_i[15:11];
  assign g6 = pixel_i[10:5];
  assign b5 = pixel_i[4:0];
  assign r8 = {r5, r5[4:2]};
  assign g8 = {g6, g6[5:4]};
  assign b8 = {b5, b5[4:2]};

  // weights sum to 256 so the total fits 16 bits
  assign wsum = 16'(16'd77 * 16'(r8)) + 16'(16'd150 * 16'(g8)) + 16'(16'd29 * 16'(b8));
  assign luma_o = wsum[15:8];

  always_comb begin
    case (mode_i)
      rgbs_pkg::ModeGray: begin
        pixel_o = {luma_o[7:3], luma_o[7:2], luma_o[7:3]};
      end
      rgbs_pkg::ModeBinary: begin
        pixel_o = (luma_o >= threshold_i) ? 16'hFFFF : 16'h0000;
      end
      default: begin
        pixel_o = pixel_i;
      end
    endcase
  end

endmodule

>>> rtl/rgbs_stats.sv
// per-frame luma statistics registers with saturating update
`timescale 1ns / 1ps

module rgbs_stats (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        upd_i,
  input  logic                        frame_start_i,
  input  logic [rgbs_pkg::LumaW-1:0]  luma_i,
  input  logic [rgbs_pkg::ModeW-1:0]  mode_i,
  input  logic [rgbs_pkg::ThrW-1:0]   threshold_i,
  output rgbs_pkg::stats_t            stats_o
);

  rgbs_pkg::stats_t stats_q, stats_d, base;
  logic [rgbs_pkg::SumW:0] sum_ext;

  always_comb begin
    base = stats_q;
    if (frame_start_i) begin
      base = rgbs_pkg::stats_clear((mode_i == rgbs_pkg::ModeGray) ? '0 : threshold_i);
    end
    stats_d = base;
    sum_ext = {1'b0, base.total} + (rgbs_pkg::SumW + 1)'(luma_i);
    if (base.count < rgbs_pkg::TallyCapV) begin
      stats_d.count = base.count + 16'd1;
      stats_d.total = (sum_ext > {1'b0, rgbs_pkg::SumCeil}) ? rgbs_pkg::SumCeil
                                                            : sum_ext[rgbs_pkg::SumW-1:0];
      if (luma_i < base.low) begin
        stats_d.low = luma_i;
      end
      if (luma_i > base.high) begin
        stats_d.high = luma_i;
      end
      if (luma_i < rgbs_pkg::DarkLimit) begin
        stats_d.dark = base.dark + 16'd1;
      end
      if (luma_i > rgbs_pkg::BrightLimit) begin
        stats_d.bright = base.bright + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stats_q <= rgbs_pkg::stats_clear('0);
    end else if (upd_i) begin
      stats_q <= stats_d;
    end
  end

  assign stats_o = stats_d;

endmodule

>>> rtl/rgb565_gray_binarize_stats.sv
// top level: rgb565 to grey / binary pixel stream with running frame statistics
//
//  channel  | dir | handshake               | payload
//  s_axis   | in  | s_axis_tvalid/tready    | tdata: pixel_in; tuser: frame_start
//  m_axis   | out | m_axis_tvalid/tready    | tdata: pixel_out + statistics
//  cfg      | in  | cfg_we_i (no wait)      | cfg_idx_i, cfg_wdata_i
//
// one transaction per cycle sustained while the output accepts
// the input register feeds luma, pixel select and the stats update into the result register
// reset clears config, statistics and valid flags; stats reset to empty frame
// a stalled output holds both stages; input ready follows output ready when full
`timescale 1ns / 1ps

module rgb565_gray_binarize_stats (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,  // pixel_in[15:0]
  input  logic                          s_axis_tuser,  // frame_start
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // pixel_out[15:0], count_so_far[31:16], luma_total[54:32], luma_low[62:55],
  // luma_high[70:63], dark_total[86:71], bright_total[102:87],
  // threshold_snapshot[110:103], zero[111]
  output logic [rgbs_pkg::OutW-1:0]     m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [7:0]                    cfg_wdata_i
);

  logic [rgbs_pkg::ModeW-1:0]  mode_q;
  logic [rgbs_pkg::ThrW-1:0]   thr_q;

  logic                        a_valid_q;
  logic [rgbs_pkg::PixelW-1:0] a_pixel_q;
  logic                        a_start_q;

  logic                        o_valid_q;
  logic [rgbs_pkg::PixelW-1:0] o_pixel_q;
  rgbs_pkg::stats_t            o_stats_q;

  logic                        out_free;
  logic                        move;
  logic [rgbs_pkg::LumaW-1:0]  luma;
  logic [rgbs_pkg::PixelW-1:0] pixel_sel;
  rgbs_pkg::stats_t            stats_nx;

  assign out_free      = !o_valid_q || m_axis_tready;
  assign move          = a_valid_q && out_free;
  assign s_axis_tready = !a_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= rgbs_pkg::ModeBypass;
      thr_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rgbs_pkg::RegMode:      mode_q <= cfg_wdata_i[1:0];
        rgbs_pkg::RegThreshold: thr_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        a_valid_q <= s_axis_tvalid;
      end
      if (out_free) begin
        o_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      a_pixel_q <= s_axis_tdata;
      a_start_q <= s_axis_tuser;
    end
    if (move) begin
      o_pixel_q <= pixel_sel;
      o_stats_q <= stats_nx;
    end
  end

  rgbs_luma u_luma (
    .pixel_i     (a_pixel_q),
    .mode_i      (mode_q),
    .threshold_i (thr_q),
    .luma_o      (luma),
    .pixel_o     (pixel_sel)
  );

  rgbs_stats u_stats (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .upd_i         (move),
    .frame_start_i (a_start_q),
    .luma_i        (luma),
    .mode_i        (mode_q),
    .threshold_i   (thr_q),
    .stats_o       (stats_nx)
  );

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = {1'b0, o_stats_q.snap, o_stats_q.bright, o_stats_q.dark,
                          o_stats_q.high, o_stats_q.low, o_stats_q.total,
                          o_stats_q.count, o_pixel_q};

  // every delivered result counts at least one pixel, so min never exceeds max
  a_minmax : assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_valid_q |-> (o_stats_q.count != '0) && (o_stats_q.low <= o_stats_q.high))
    else $error("stats min above max or empty count");

  a_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_valid_q |-> (o_stats_q.count <= rgbs_pkg::TallyCapV) &&
                  (o_stats_q.dark <= o_stats_q.count) &&
                  (o_stats_q.bright <= o_stats_q.count))
    else $error("tally beyond cap or pixel count");

  a_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !o_valid_q |-> s_axis_tready)
    else $error("input stalled with empty result register");

endmodule

>>> bench/tb.sv
// self-checking bench: per-pixel prediction of luma output and frame statistics, scoreboarded
`timescale 1ns / 1ps

typedef struct {
  logic [rgbs_pkg::PixelW-1:0] pixel;
  rgbs_pkg::stats_t            stats;
} pixel_result_t;

class luma_stats_board;
  logic [rgbs_pkg::ModeW-1:0] mode;
  logic [rgbs_pkg::ThrW-1:0]  thr;
  rgbs_pkg::stats_t           frame;
  pixel_result_t              expected_q[$];
  int unsigned                mismatches;
  int unsigned                results_seen;

  function new();
    mode = rgbs_pkg::ModeBypass;
    thr = '0;
    restart_frame('0);
    mismatches = 0;
    results_seen = 0;
  endfunction

  function void restart_frame(logic [rgbs_pkg::ThrW-1:0] snap);
    frame.count  = '0;
    frame.total  = '0;
    frame.low    = '1;
    frame.high   = '0;
    frame.dark   = '0;
    frame.bright = '0;
    frame.snap   = snap;
  endfunction

  function logic [rgbs_pkg::LumaW-1:0] luma_of(logic [rgbs_pkg::PixelW-1:0] px);
    logic [7:0]  r8;
    logic [7:0]  g8;
    logic [7:0]  b8;
    logic [17:0] acc;
    r8 = {px[15:11], px[15:13]};
    g8 = {px[10:5], px[10:9]};
    b8 = {px[4:0], px[4:2]};
    acc = 18'd77 * r8 + 18'd150 * g8 + 18'd29 * b8;
    return acc[15:8];
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void note_pixel(logic [rgbs_pkg::PixelW-1:0] px, logic opens_frame);
    logic [rgbs_pkg::LumaW-1:0] y;
    logic [rgbs_pkg::SumW:0]    sum;
    pixel_result_t              r;
    y = luma_of(px);
    if (opens_frame) begin
      restart_frame((mode == rgbs_pkg::ModeGray) ? {rgbs_pkg::ThrW{1'b0}} : thr);
    end
    case (mode)
      rgbs_pkg::ModeGray:   r.pixel = {y[7:3], y[7:2], y[7:3]};
      rgbs_pkg::ModeBinary: begin
        r.pixel = (y >= thr) ? {rgbs_pkg::PixelW{1'b1}} : {rgbs_pkg::PixelW{1'b0}};
      end
      default:              r.pixel = px;
    endcase
    // a full frame freezes every statistic until the next frame start
    if (frame.count < rgbs_pkg::TallyCapV) begin
      frame.count++;
      sum = frame.total + y;
      frame.total = (sum > rgbs_pkg::SumCeil) ? rgbs_pkg::SumCeil : sum[rgbs_pkg::SumW-1:0];
      if (y < frame.low) frame.low = y;
      if (y > frame.high) frame.high = y;
      if (y < rgbs_pkg::DarkLimit) frame.dark++;
      if (y > rgbs_pkg::BrightLimit) frame.bright++;
    end
    r.stats = frame;
    expected_q.push_back(r);
  endfunction

  task report(string what, logic [rgbs_pkg::SumW-1:0] got, logic [rgbs_pkg::SumW-1:0] want);
    mismatches++;
    $display("mismatch at result %0d, %s: got 0x%0h, expected 0x%0h",
             results_seen, what, got, want);
  endtask

  task check_field(string what, logic [rgbs_pkg::SumW-1:0] got,
                   logic [rgbs_pkg::SumW-1:0] want);
    if (got !== want) report(what, got, want);
  endtask

  task check_result(logic [rgbs_pkg::OutW-1:0] d);
    pixel_result_t e;
    results_seen++;
    if (expected_q.size() == 0) begin
      report("result with no pixel pending", d[15:0], '0);
      return;
    end
    e = expected_q.pop_front();
    check_field("pixel_out", d[15:0], e.pixel);
    check_field("count_so_far", d[31:16], e.stats.count);
    check_field("luma_total", d[54:32], e.stats.total);
    check_field("luma_low", d[62:55], e.stats.low);
    check_field("luma_high", d[70:63], e.stats.high);
    check_field("dark_total", d[86:71], e.stats.dark);
    check_field("bright_total", d[102:87], e.stats.bright);
    check_field("threshold_snapshot", d[110:103], e.stats.snap);
    check_field("pad bit", d[111], 1'b0);
  endtask
endclass

module tb;

  localparam logic [rgbs_pkg::ModeW-1:0]   ModeSpare  = 2'd3;
  localparam logic [4*rgbs_pkg::ModeW-1:0] ModeOrder  = {ModeSpare, rgbs_pkg::ModeBinary,
                                                         rgbs_pkg::ModeGray,
                                                         rgbs_pkg::ModeBypass};
  localparam int                           StallLimit = 3000;
  localparam int                           HoldCycles = 300;

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [15:0]                 s_axis_tdata  = '0;
  logic                        s_axis_tuser  = 1'b0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [rgbs_pkg::OutW-1:0]   m_axis_tdata;
  logic                        cfg_we_i      = 1'b0;
  logic                        cfg_idx_i     = 1'b0;
  logic [7:0]                  cfg_wdata_i   = '0;

  int                send_idle_pct = 33;
  int                recv_idle_pct = 72;
  bit                hold_req      = 1'b0;
  int                stall_cycles  = 0;

  luma_stats_board   sb = new();

  rgb565_gray_binarize_stats i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_pixel(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
        $display("timeout: no transaction for %0d cycles", StallLimit);
        $display("rgb565_gray_binarize_stats verification failed");
        $finish;
      end
    end
  end

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic push_pixel(logic [15:0] px, logic opens_frame);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    s_axis_tuser  <= opens_frame;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    if (idx == rgbs_pkg::RegMode) sb.mode = val[rgbs_pkg::ModeW-1:0];
    else sb.thr = val;
  endtask

  function automatic logic [15:0] pixel_with_luma(logic [7:0] y);
    for (int p = 0; p < 65536; p++) begin
      if (sb.luma_of(p[15:0]) == y) return p[15:0];
    end
    return 16'h0000;
  endfunction

  function automatic logic [15:0] random_pixel();
    logic [15:0] p;
    p = 16'($urandom_range(16'hFFFF));
    case ($urandom_range(7))
      0:       p = p & 16'h18E3;
      1:       p = p | 16'hE79C;
      2:       p = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: ;
    endcase
    return p;
  endfunction

  initial begin : stimulus
    logic [7:0] thr_val;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // bypass with reset config: extremes, pure channels, dark and bright edges
    push_pixel(16'h0000, 1'b1);
    push_pixel(16'hFFFF, 1'b0);
    push_pixel(16'hF800, 1'b0);
    push_pixel(16'h07E0, 1'b0);
    push_pixel(16'h001F, 1'b0);
    push_pixel(pixel_with_luma(8'd29), 1'b0);
    push_pixel(pixel_with_luma(8'd30), 1'b0);
    push_pixel(pixel_with_luma(8'd240), 1'b0);
    push_pixel(pixel_with_luma(8'd241), 1'b0);
    settle();

    // grayscale frame records a zero snapshot
    write_reg(rgbs_pkg::RegThreshold, 8'd100);
    write_reg(rgbs_pkg::RegMode, 8'(rgbs_pkg::ModeGray));
    push_pixel(16'h1234, 1'b1);
    push_pixel(16'hFFFF, 1'b0);
    push_pixel(16'h0000, 1'b0);
    settle();

    write_reg(rgbs_pkg::RegMode, 8'(rgbs_pkg::ModeBinary));
    write_reg(rgbs_pkg::RegThreshold, 8'd128);
    push_pixel(pixel_with_luma(8'd128), 1'b1);
    push_pixel(pixel_with_luma(8'd127), 1'b0);
    push_pixel(16'h0000, 1'b0);
    push_pixel(16'hFFFF, 1'b0);
    settle();

    // live threshold changes inside the frame, snapshot stays
    write_reg(rgbs_pkg::RegThreshold, 8'd0);
    push_pixel(16'h0000, 1'b0);
    settle();
    write_reg(rgbs_pkg::RegThreshold, 8'd255);
    push_pixel(16'hFFFF, 1'b0);
    push_pixel(pixel_with_luma(8'd254), 1'b0);
    settle();

    // unused mode acts as bypass
    write_reg(rgbs_pkg::RegMode, 8'(ModeSpare));
    push_pixel(16'hABCD, 1'b1);
    push_pixel(16'h5555, 1'b0);
    settle();

    for (int seg = 0; seg < 12; seg++) begin
      if (seg == 4) begin
        send_idle_pct = 72;
        recv_idle_pct = 33;
      end
      if (seg == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (seg % 3)
        0:       thr_val = 8'd0;
        1:       thr_val = 8'hFF;
        default: thr_val = 8'($urandom_range(255));
      endcase
      write_reg(rgbs_pkg::RegMode,
                8'(ModeOrder[(seg % 4)*rgbs_pkg::ModeW +: rgbs_pkg::ModeW]));
      write_reg(rgbs_pkg::RegThreshold, thr_val);
      // output held off while input keeps coming, so the pipeline backs up
      if (seg == 8) hold_req = 1'b1;
      for (int n = 0; n < 120; n++) begin
        push_pixel(random_pixel(),
                   (n == 0) ? 1'($urandom_range(1)) : ($urandom_range(39) == 0));
      end
      settle();
    end

    repeat (10) @(negedge clk_i);
    if (sb.mismatches == 0) begin
      $display("rgb565_gray_binarize_stats verification clean");
    end else begin
      $display("rgb565_gray_binarize_stats verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/rgbs_pkg.sv
rtl/rgbs_luma.sv
rtl/rgbs_stats.sv
rtl/rgb565_gray_binarize_stats.sv
bench/tb.sv
